FILE: src/cts_pkg.sv
// Shared types and codes for the cooperative task scheduler.
package cts_pkg;

  // Default configuration
  localparam int SLOTS_DEF   = 8;
  localparam int TICK_MS_DEF = 10;
  localparam int MAX_RESULTS = 8;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  // Operation codes
  localparam logic [1:0] OP_ADD      = 2'd0;
  localparam logic [1:0] OP_DELETE   = 2'd1;
  localparam logic [1:0] OP_TICK     = 2'd2;
  localparam logic [1:0] OP_DISPATCH = 2'd3;

  // Result kinds
  localparam logic [2:0] KIND_ADDED   = 3'd0;
  localparam logic [2:0] KIND_FULL    = 3'd1;
  localparam logic [2:0] KIND_DELETED = 3'd2;
  localparam logic [2:0] KIND_IGNORED = 3'd3;
  localparam logic [2:0] KIND_RUN     = 3'd4;

  typedef struct packed {
    logic [1:0]  operation;
    logic [7:0]  task_handle;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
    logic [7:0]  slot_index;
  } cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic [5:0] slot;
    logic [7:0] task_handle_out;
    logic       last;
  } rsp_t;

  // One slot of the task table as kept in memory
  typedef struct packed {
    logic [7:0]  handle;
    logic [31:0] delay_left;
    logic [31:0] period_ticks;
    logic [7:0]  run_count;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: src/cts_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/cts_div.sv
// Divider of a 32-bit value by a constant: reciprocal multiply, one 16-bit half per cycle.
module cts_div #(
  parameter int DIVISOR = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        go,
  input  logic [31:0] dividend,
  output logic        done,
  output logic [31:0] quotient
);

  // Rounded-up reciprocal of 2^SH / DIVISOR gives an exact quotient for any 32-bit dividend
  localparam int          LG       = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
  localparam int          SH       = 32 + LG;
  localparam int          ACC_W    = SH + 32;
  localparam logic [63:0] DIV_64   = 64'(DIVISOR);
  localparam logic [63:0] RECIP_64 = ((64'd1 << SH) + DIV_64 - 64'd1) / DIV_64;
  localparam logic [32:0] RECIP    = RECIP_64[32:0];

  logic [31:0]      x;
  logic [ACC_W-1:0] acc;
  logic             step;
  logic             running;
  logic [15:0]      half;
  logic [48:0]      prod;

  // Shared multiplier: one half of the dividend times the reciprocal
  always_comb begin
    half = step ? x[31:16] : x[15:0];
    prod = {33'd0, half} * {16'd0, RECIP};
  end

  // Take the low half first, then add the high half shifted up
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        x       <= dividend;
        step    <= 1'b0;
        running <= 1'b1;
      end else if (running) begin
        if (!step) begin
          acc  <= ACC_W'(prod);
          step <= 1'b1;
        end else begin
          acc     <= acc + (ACC_W'(prod) << 16);
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign quotient = acc[SH +: 32];

  a_go_idle: assert property (@(posedge clk) disable iff (rst) go |-> !running)
    else $error("divider started while running");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !running)
    else $error("divider done while still running");
  a_go_starts: assert property (@(posedge clk) disable iff (rst)
    go |=> running && step == 1'b0)
    else $error("divider did not start after go");

endmodule

FILE: src/cooperative_task_scheduler_unit.sv
// Top level of the cooperative task scheduler: sequencer, slot table and divider.
//
// Usage: drive cmd and raise start; the command transfers at a rising edge with
// start high and busy low. Results appear on rsp for exactly one cycle, marked
// by rsp_valid; rsp.last flags the final result of a command. The receiver
// cannot stall the block, so every result must be taken in its cycle.
// Per command:
//   delete   : handled at transfer, result in the next cycle.
//   add      : free-slot search (a full table ends it with a full result), then
//              two passes of the shared reciprocal multiplier (delay, then
//              period); the result comes in the cycle busy falls.
//   tick     : one table slot read, and written back if in use, per cycle.
//   dispatch : at most one run result per cycle.
// The table memory has one read and one write port; that port pair sets the
// one-slot-per-cycle scan rate. busy stays high while a command is in work.
// Reset frees every slot at once through per-slot valid bits; no clearing pass.
module cooperative_task_scheduler_unit
  import cts_pkg::*;
#(
  parameter int SLOTS   = SLOTS_DEF,
  parameter int TICK_MS = TICK_MS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  cmd_t cmd,
  output logic busy,
  output logic rsp_valid,
  output rsp_t rsp
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = IDX_W + 1;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_FIND = 3'd1;
  localparam logic [2:0] ST_DIVD = 3'd2;
  localparam logic [2:0] ST_DIVP = 3'd3;
  localparam logic [2:0] ST_SCAN = 3'd4;

  logic [2:0]        state;
  logic [CNT_W-1:0]  cnt;
  logic [1:0]        op_r;
  logic [7:0]        handle_r;
  logic [31:0]       delay_r;
  logic [31:0]       period_r;
  logic [IDX_W-1:0]  free_slot;
  logic [31:0]       dly_ticks;
  logic [SLOTS-1:0]  valid;
  logic              rd_pend;
  logic [IDX_W-1:0]  rd_slot;
  logic              pend;
  logic [IDX_W-1:0]  pend_slot;
  logic [7:0]        pend_handle;
  logic [NRES_W-1:0] nres;

  logic             accept;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  entry_t           wr_entry;
  entry_t           rd_entry;
  entry_t           tick_entry;
  logic             div_go;
  logic [31:0]      div_dividend;
  logic             div_done;
  logic [31:0]      div_q;
  logic             find_free;
  logic             find_last;
  logic             scan_done;
  logic             full_out;
  logic             proc;
  logic             cur_valid;
  logic             hit;
  logic             finish;

  assign accept    = start && !busy;
  assign busy      = (state != ST_IDLE);
  assign find_free = !valid[cnt[IDX_W-1:0]];
  assign find_last = (cnt == CNT_W'(SLOTS - 1));
  assign scan_done = (cnt == CNT_W'(SLOTS));
  assign full_out  = (nres == NRES_W'(MAX_RESULTS));
  assign proc      = rd_pend && (op_r == OP_TICK || !full_out);
  assign cur_valid = valid[rd_slot];
  assign hit       = proc && op_r == OP_DISPATCH && cur_valid && rd_entry.run_count != 8'd0;
  assign finish    = (scan_done && !rd_pend) || full_out;

  // Slot table
  cts_ram #(.WIDTH(ENTRY_W), .DEPTH(SLOTS), .AW(IDX_W)) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(wr_entry),
    .raddr(cnt[IDX_W-1:0]),
    .rdata(rd_entry)
  );

  // Millisecond to tick conversion
  cts_div #(.DIVISOR(TICK_MS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .go      (div_go),
    .dividend(div_dividend),
    .done    (div_done),
    .quotient(div_q)
  );

  assign div_go       = (state == ST_FIND && find_free) || (state == ST_DIVD && div_done);
  assign div_dividend = (state == ST_FIND) ? delay_r : period_r;

  // Tick update of one slot
  always_comb begin
    tick_entry = rd_entry;
    if (rd_entry.delay_left == 32'd0) begin
      if (rd_entry.run_count != 8'hFF) begin
        tick_entry.run_count = rd_entry.run_count + 8'd1;
      end
      if (rd_entry.period_ticks != 32'd0) begin
        tick_entry.delay_left = rd_entry.period_ticks;
      end
    end else begin
      tick_entry.delay_left = rd_entry.delay_left - 32'd1;
    end
  end

  // Table write: new entry on add, write-back during a scan
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = rd_slot;
    wr_entry  = rd_entry;
    if (state == ST_DIVP && div_done) begin
      ram_we    = 1'b1;
      ram_waddr = free_slot;
      wr_entry  = '{handle: handle_r, delay_left: dly_ticks, period_ticks: div_q,
                    run_count: 8'd0};
    end else if (state == ST_SCAN && proc && cur_valid && op_r == OP_TICK) begin
      ram_we   = 1'b1;
      wr_entry = tick_entry;
    end else if (state == ST_SCAN && hit) begin
      ram_we             = 1'b1;
      wr_entry.run_count = rd_entry.run_count - 8'd1;
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      valid     <= '0;
      rd_pend   <= 1'b0;
      pend      <= 1'b0;
      nres      <= '0;
      rsp_valid <= 1'b0;
    end else begin
      rsp_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            op_r     <= cmd.operation;
            handle_r <= cmd.task_handle;
            delay_r  <= cmd.delay_ms;
            period_r <= cmd.period_ms;
            cnt      <= '0;
            nres     <= '0;
            pend     <= 1'b0;
            rd_pend  <= 1'b0;
            unique case (cmd.operation)
              OP_ADD: begin
                state <= ST_FIND;
              end
              OP_DELETE: begin
                rsp_valid <= 1'b1;
                if (cmd.slot_index < 8'(SLOTS) && valid[cmd.slot_index[IDX_W-1:0]]) begin
                  valid[cmd.slot_index[IDX_W-1:0]] <= 1'b0;
                  rsp <= '{kind: KIND_DELETED, slot: cmd.slot_index[5:0],
                           task_handle_out: 8'd0, last: 1'b1};
                end else begin
                  rsp <= '{kind: KIND_IGNORED, slot: cmd.slot_index[5:0],
                           task_handle_out: 8'd0, last: 1'b1};
                end
              end
              default: begin
                state <= ST_SCAN;
              end
            endcase
          end
        end
        ST_FIND: begin
          // Search for the lowest free slot
          if (find_free) begin
            free_slot <= cnt[IDX_W-1:0];
            state     <= ST_DIVD;
          end else if (find_last) begin
            rsp_valid <= 1'b1;
            rsp       <= '{kind: KIND_FULL, slot: 6'd0, task_handle_out: 8'd0, last: 1'b1};
            state     <= ST_IDLE;
          end else begin
            cnt <= cnt + CNT_W'(1);
          end
        end
        ST_DIVD: begin
          if (div_done) begin
            dly_ticks <= div_q;
            state     <= ST_DIVP;
          end
        end
        ST_DIVP: begin
          if (div_done) begin
            valid[free_slot] <= 1'b1;
            rsp_valid        <= 1'b1;
            rsp <= '{kind: KIND_ADDED, slot: 6'(free_slot), task_handle_out: 8'd0,
                     last: 1'b1};
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (finish) begin
            // Flush the held run result as the final one
            state   <= ST_IDLE;
            rd_pend <= 1'b0;
            pend    <= 1'b0;
            if (pend) begin
              rsp_valid <= 1'b1;
              rsp <= '{kind: KIND_RUN, slot: 6'(pend_slot), task_handle_out: pend_handle,
                       last: 1'b1};
            end
          end else begin
            // Issue the read of the next slot
            if (!scan_done) begin
              cnt     <= cnt + CNT_W'(1);
              rd_pend <= 1'b1;
              rd_slot <= cnt[IDX_W-1:0];
            end else begin
              rd_pend <= 1'b0;
            end
            // Hold one ready slot back so the last result can be flagged
            if (hit) begin
              if (rd_entry.period_ticks == 32'd0) begin
                valid[rd_slot] <= 1'b0;
              end
              if (pend) begin
                rsp_valid <= 1'b1;
                rsp <= '{kind: KIND_RUN, slot: 6'(pend_slot), task_handle_out: pend_handle,
                         last: 1'b0};
              end
              pend        <= 1'b1;
              pend_slot   <= rd_slot;
              pend_handle <= rd_entry.handle;
              nres        <= nres + NRES_W'(1);
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_rd_in_scan: assert property (@(posedge clk) disable iff (rst) rd_pend |-> state == ST_SCAN)
    else $error("slot read pending outside a scan");
  a_nres_max: assert property (@(posedge clk) disable iff (rst)
    nres <= NRES_W'(MAX_RESULTS))
    else $error("dispatch result count overflow");
  a_run_from_dispatch: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.kind == KIND_RUN |-> op_r == OP_DISPATCH)
    else $error("run result outside dispatch");
  a_tick_silent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> op_r != OP_TICK)
    else $error("tick produced a result");

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the cooperative task scheduler unit.
`timescale 1ns / 1ps

module testbench;
  import cts_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [31:0] TICK_LEN = TICK_MS_DEF;

  typedef struct {
    cmd_t        c;
    int unsigned gap;
    bit          drain;
  } item_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  cmd_t cmd = '0;
  logic busy;
  logic rsp_valid;
  rsp_t rsp;

  // Expected contents of the task table
  bit          slot_used [SLOTS];
  logic [7:0]  slot_handle [SLOTS];
  logic [31:0] slot_delay [SLOTS];
  logic [31:0] slot_period [SLOTS];
  logic [7:0]  slot_runs [SLOTS];

  item_t pending_items[$];
  rsp_t  awaited_rsps[$];
  bit    back_to_back = 1'b0;

  int unsigned gap_left = 0;
  bit          gap_loaded = 1'b0;
  int          rsps_due = 0;
  int          rsps_got = 0;
  int          mismatches = 0;
  int          op_count [4];
  int          n_checked = 0;
  int          n_runs = 0;
  int          n_full = 0;
  int          n_ignored = 0;

  cooperative_task_scheduler_unit #(
    .SLOTS   (SLOTS),
    .TICK_MS (TICK_MS_DEF)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd       (cmd),
    .busy      (busy),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

  always #1 clk = ~clk;

  task automatic clear_slot(input int s);
    slot_used[s] = 1'b0;
    slot_handle[s] = '0;
    slot_delay[s] = '0;
    slot_period[s] = '0;
    slot_runs[s] = '0;
  endtask

  // Apply one command to the expected table and queue the results it causes
  task automatic table_step(input cmd_t c);
    rsp_t batch [MAX_RESULTS];
    rsp_t r;
    int   free_slot;
    int   n;
    r = '0;
    r.last = 1'b1;
    n = 0;
    case (c.operation)
      OP_ADD: begin
        free_slot = -1;
        for (int s = 0; s < SLOTS; s++)
          if (!slot_used[s] && free_slot < 0) free_slot = s;
        if (free_slot < 0) begin
          r.kind = KIND_FULL;
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_handle[free_slot] = c.task_handle;
          slot_delay[free_slot] = c.delay_ms / TICK_LEN;
          slot_period[free_slot] = c.period_ms / TICK_LEN;
          slot_runs[free_slot] = '0;
          r.kind = KIND_ADDED;
          r.slot = 6'(free_slot);
        end
        batch[0] = r;
        n = 1;
      end
      OP_DELETE: begin
        r.slot = c.slot_index[5:0];
        if (c.slot_index < SLOTS && slot_used[c.slot_index]) begin
          clear_slot(c.slot_index);
          r.kind = KIND_DELETED;
        end else begin
          r.kind = KIND_IGNORED;
        end
        batch[0] = r;
        n = 1;
      end
      OP_TICK: begin
        for (int s = 0; s < SLOTS; s++) begin
          if (!slot_used[s]) continue;
          if (slot_delay[s] == 0) begin
            if (slot_runs[s] != 8'hFF) slot_runs[s]++;
            if (slot_period[s] != 0) slot_delay[s] = slot_period[s];
          end else begin
            slot_delay[s]--;
          end
        end
      end
      default: begin
        for (int s = 0; s < SLOTS && n < MAX_RESULTS; s++) begin
          if (!slot_used[s] || slot_runs[s] == 0) continue;
          r.kind = KIND_RUN;
          r.slot = 6'(s);
          r.task_handle_out = slot_handle[s];
          batch[n] = r;
          n++;
          slot_runs[s]--;
          if (slot_period[s] == 0) clear_slot(s);
        end
      end
    endcase
    // Flag the final result of this command
    for (int i = 0; i < n; i++) begin
      batch[i].last = (i == n - 1);
      awaited_rsps.push_back(batch[i]);
    end
    rsps_due += n;
  endtask

  function automatic cmd_t make_cmd(input logic [1:0] op, input logic [7:0] handle,
                                    input logic [31:0] dms, input logic [31:0] pms,
                                    input logic [7:0] idx);
    cmd_t c;
    c.operation = op;
    c.task_handle = handle;
    c.delay_ms = dms;
    c.period_ms = pms;
    c.slot_index = idx;
    return c;
  endfunction

  // Mostly short delays and periods so tasks fire often; some full-range values
  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick;
    c = make_cmd(OP_TICK, 8'($urandom), $urandom, $urandom, 8'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 28) begin
      c.operation = OP_ADD;
      if ($urandom_range(0, 9) != 0) c.delay_ms = $urandom_range(0, 60);
      case ($urandom_range(0, 9))
        0, 1, 2: c.period_ms = '0;
        9: ;
        default: c.period_ms = $urandom_range(1, 50);
      endcase
    end else if (pick < 40) begin
      c.operation = OP_DELETE;
      if ($urandom_range(0, 7) != 0) c.slot_index = $urandom_range(0, SLOTS - 1);
    end else if (pick < 75) begin
      c.operation = OP_TICK;
    end else begin
      c.operation = OP_DISPATCH;
    end
    return c;
  endfunction

  task automatic queue_cmd(input cmd_t c, input bit drain);
    item_t it;
    it.c = c;
    it.gap = back_to_back ? 0 : $urandom_range(0, 12);
    it.drain = drain;
    pending_items.push_back(it);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // Driver: present pending commands, honoring gaps and drain requests
  always @(posedge clk) begin : drive
    item_t head;
    int unsigned g;
    bit fire;
    if (rst) begin
      start <= 1'b0;
      cmd <= '0;
      gap_left <= 0;
      gap_loaded <= 1'b0;
      for (int s = 0; s < SLOTS; s++) clear_slot(s);
    end else begin
      fire = start && !busy;
      if (fire) begin
        table_step(cmd);
        op_count[cmd.operation]++;
      end
      if (start && !fire) begin
        // hold the command until it transfers
      end else if (pending_items.size() == 0) begin
        start <= 1'b0;
      end else begin
        head = pending_items[0];
        g = gap_loaded ? gap_left : head.gap;
        if (g != 0) begin
          gap_left <= g - 1;
          gap_loaded <= 1'b1;
          start <= 1'b0;
        end else if (head.drain && rsps_got < rsps_due) begin
          gap_left <= 0;
          gap_loaded <= 1'b1;
          start <= 1'b0;
        end else begin
          void'(pending_items.pop_front());
          cmd <= head.c;
          start <= 1'b1;
          gap_loaded <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin : watch
    rsp_t want;
    if (!rst && rsp_valid) begin
      rsps_got <= rsps_got + 1;
      if (awaited_rsps.size() == 0) begin
        $error("unexpected result: kind %0d slot %0d", rsp.kind, rsp.slot);
        mismatches++;
      end else begin
        want = awaited_rsps.pop_front();
        check_field("kind", want.kind, rsp.kind);
        check_field("slot", want.slot, rsp.slot);
        check_field("task_handle_out", want.task_handle_out, rsp.task_handle_out);
        check_field("last", want.last, rsp.last);
        n_checked++;
        if (want.kind == KIND_RUN) n_runs++;
        if (want.kind == KIND_FULL) n_full++;
        if (want.kind == KIND_IGNORED) n_ignored++;
      end
    end
  end

  // Stimulus and end of run
  initial begin : stimulus
    int guard;
    // Empty table: nothing fires
    queue_cmd(make_cmd(OP_DISPATCH, 8'h00, '0, '0, 8'h00), 1'b0);
    queue_cmd(make_cmd(OP_TICK, 8'hFF, '1, '1, 8'hFF), 1'b0);
    // Fill the table: handle zero, full-range times, sub-tick times, one-shots
    queue_cmd(make_cmd(OP_ADD, 8'h00, 32'd0, 32'd0, 8'h00), 1'b0);
    queue_cmd(make_cmd(OP_ADD, 8'hFF, '1, '1, 8'h00), 1'b0);
    queue_cmd(make_cmd(OP_ADD, 8'hA5, 32'd9, 32'd10, 8'h00), 1'b0);
    queue_cmd(make_cmd(OP_ADD, 8'h5A, 32'd25, 32'd0, 8'h00), 1'b0);
    for (int i = 0; i < SLOTS - 4; i++)
      queue_cmd(make_cmd(OP_ADD, 8'($urandom), $urandom_range(0, 30),
                         $urandom_range(0, 30), 8'h00), 1'b0);
    // Table full, then deletes out of range
    queue_cmd(make_cmd(OP_ADD, 8'h3C, 32'd0, 32'd0, 8'h00), 1'b0);
    queue_cmd(make_cmd(OP_DELETE, 8'h00, '0, '0, 8'hFF), 1'b0);
    queue_cmd(make_cmd(OP_DELETE, 8'h00, '0, '0, 8'(SLOTS)), 1'b0);
    queue_cmd(make_cmd(OP_DELETE, 8'h00, '0, '0, 8'd67), 1'b0);
    for (int i = 0; i < 3; i++) queue_cmd(make_cmd(OP_TICK, 8'h00, '0, '0, 8'h00), 1'b0);
    queue_cmd(make_cmd(OP_DISPATCH, 8'h00, '0, '0, 8'h00), 1'b0);
    // Delete a live slot, then the same slot again, then add into the lowest free slot
    queue_cmd(make_cmd(OP_DELETE, 8'h00, '0, '0, 8'd1), 1'b0);
    queue_cmd(make_cmd(OP_DELETE, 8'h00, '0, '0, 8'd1), 1'b0);
    queue_cmd(make_cmd(OP_ADD, 8'h81, 32'd10, 32'd20, 8'h00), 1'b0);
    for (int s = 0; s < SLOTS; s++)
      queue_cmd(make_cmd(OP_DELETE, 8'h00, '0, '0, 8'(s)), 1'b0);

    // Run-count saturation: a ready one-shot ticked past 255 must still run once
    back_to_back = 1'b1;
    queue_cmd(make_cmd(OP_ADD, 8'h77, 32'd0, 32'd0, 8'h00), 1'b1);
    for (int i = 0; i < 256; i++) queue_cmd(make_cmd(OP_TICK, 8'h00, '0, '0, 8'h00), 1'b0);
    queue_cmd(make_cmd(OP_DISPATCH, 8'h00, '0, '0, 8'h00), 1'b0);

    // Random traffic in segments, alternating gapped and back-to-back issue
    for (int seg = 0; seg < 4; seg++) begin
      back_to_back = seg[0];
      for (int i = 0; i < 10; i++)
        queue_cmd(random_cmd(), i == 0 && seg % 3 == 0);
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Drain stimulus, then outstanding results, then settle
    while (pending_items.size() != 0 || start) @(negedge clk);
    guard = 0;
    while (awaited_rsps.size() != 0 && guard < 4000) begin
      @(negedge clk);
      guard++;
    end
    repeat (SLOTS + 80) @(negedge clk);
    if (awaited_rsps.size() != 0) begin
      $error("%0d expected results never arrived", awaited_rsps.size());
      mismatches++;
    end

    $display("Ran %0d commands: %0d add, %0d delete, %0d tick, %0d dispatch.",
             op_count[OP_ADD] + op_count[OP_DELETE] + op_count[OP_TICK] +
             op_count[OP_DISPATCH], op_count[OP_ADD], op_count[OP_DELETE],
             op_count[OP_TICK], op_count[OP_DISPATCH]);
    $display("Checked %0d results: %0d task runs, %0d table full, %0d ignored deletes.",
             n_checked, n_runs, n_full, n_ignored);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Watchdog for a hung run
  initial begin : watchdog
    #1_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
